/* rtl/core/lzss_pkg.sv */
// Shared token codes and constants for the LZSS stream expander.
package lzss_pkg;

    localparam int LIT_BITS = 8;

    typedef enum logic [1:0] {
        TOK_LIT,
        TOK_MATCH,
        TOK_END
    } t_tok_kind;

endpackage

/* rtl/core/lzss_unpack.sv */
// Bit-serial token unpacker: shifts compressed bytes out MSB first, one bit per cycle unless a token waits.
module lzss_unpack
    import lzss_pkg::*;
#(
    parameter int INDEX_BITS  = 12,
    parameter int LENGTH_BITS = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_enable,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_in_byte,
    output logic                   o_tok_valid,
    input  logic                   i_tok_ready,
    output t_tok_kind              o_tok_kind,
    output logic [LIT_BITS-1:0]    o_tok_lit,
    output logic [INDEX_BITS-1:0]  o_tok_pos,
    output logic [LENGTH_BITS-1:0] o_tok_len
);

    localparam int CW = $clog2(INDEX_BITS);

    typedef enum logic [1:0] {
        PS_FLAG,
        PS_LIT,
        PS_POS,
        PS_LEN
    } t_state;

    t_state                 r_state, n_state;
    logic [7:0]             r_sreg, n_sreg;
    logic [3:0]             r_bits_left, n_bits_left;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [INDEX_BITS-1:0]  r_field, n_field;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic                   r_tok_valid, n_tok_valid;
    t_tok_kind              r_tok_kind, n_tok_kind;

    logic                   in_acc;
    logic                   shift_en;
    logic                   bit_in;
    logic [INDEX_BITS-1:0]  field_next;
    logic [LENGTH_BITS-1:0] len_next;

    assign o_in_ready  = i_enable && (r_bits_left == 4'd0);
    assign in_acc      = i_in_valid && o_in_ready;
    assign shift_en    = (r_bits_left != 4'd0) && !r_tok_valid;
    assign bit_in      = r_sreg[7];
    assign field_next  = {r_field[INDEX_BITS-2:0], bit_in};
    assign len_next    = {r_len[LENGTH_BITS-2:0], bit_in};

    assign o_tok_valid = r_tok_valid;
    assign o_tok_kind  = r_tok_kind;
    assign o_tok_lit   = r_field[LIT_BITS-1:0];
    assign o_tok_pos   = r_field;
    assign o_tok_len   = r_len;

    always_comb begin
        n_state     = r_state;
        n_sreg      = r_sreg;
        n_bits_left = r_bits_left;
        n_cnt       = r_cnt;
        n_field     = r_field;
        n_len       = r_len;
        n_tok_valid = r_tok_valid;
        n_tok_kind  = r_tok_kind;

        if (r_tok_valid && i_tok_ready) begin
            n_tok_valid = 1'b0;
        end

        if (in_acc) begin
            n_sreg      = i_in_byte;
            n_bits_left = 4'd8;
        end else if (shift_en) begin
            n_sreg      = {r_sreg[6:0], 1'b0};
            n_bits_left = r_bits_left - 4'd1;
            n_cnt       = r_cnt + CW'(1);
            unique case (r_state)
                PS_FLAG: begin
                    n_cnt   = '0;
                    n_state = bit_in ? PS_LIT : PS_POS;
                end
                PS_LIT: begin
                    n_field = field_next;
                    if (r_cnt == CW'(LIT_BITS - 1)) begin
                        n_tok_valid = 1'b1;
                        n_tok_kind  = TOK_LIT;
                        n_state     = PS_FLAG;
                    end
                end
                PS_POS: begin
                    n_field = field_next;
                    if (r_cnt == CW'(INDEX_BITS - 1)) begin
                        n_cnt = '0;
                        if (field_next == '0) begin
                            // End marker: the rest of this byte is thrown away.
                            n_tok_valid = 1'b1;
                            n_tok_kind  = TOK_END;
                            n_bits_left = 4'd0;
                            n_state     = PS_FLAG;
                        end else begin
                            n_state = PS_LEN;
                        end
                    end
                end
                PS_LEN: begin
                    n_len = len_next;
                    if (r_cnt == CW'(LENGTH_BITS - 1)) begin
                        n_tok_valid = 1'b1;
                        n_tok_kind  = TOK_MATCH;
                        n_state     = PS_FLAG;
                    end
                end
                default: n_state = PS_FLAG;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= PS_FLAG;
            r_bits_left <= 4'd0;
            r_cnt       <= '0;
            r_tok_valid <= 1'b0;
            r_tok_kind  <= TOK_LIT;
        end else begin
            r_state     <= n_state;
            r_bits_left <= n_bits_left;
            r_cnt       <= n_cnt;
            r_tok_valid <= n_tok_valid;
            r_tok_kind  <= n_tok_kind;
        end
        r_sreg  <= n_sreg;
        r_field <= n_field;
        r_len   <= n_len;
    end

endmodule

/* rtl/core/lzss_window.sv */
// History window memory, match copy engine and output word register.
module lzss_window
    import lzss_pkg::*;
#(
    parameter int INDEX_BITS  = 12,
    parameter int LENGTH_BITS = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    output logic                   o_clear_done,
    input  logic                   i_tok_valid,
    output logic                   o_tok_ready,
    input  t_tok_kind              i_tok_kind,
    input  logic [LIT_BITS-1:0]    i_tok_lit,
    input  logic [INDEX_BITS-1:0]  i_tok_pos,
    input  logic [LENGTH_BITS-1:0] i_tok_len,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [7:0]             o_data_byte,
    output logic                   o_data_valid,
    output logic                   o_stream_end,
    output logic                   o_last_of_run
);

    localparam int DEPTH     = 1 << INDEX_BITS;
    localparam int COPY_BIAS = (1 + INDEX_BITS + LENGTH_BITS) / 9;
    localparam int CNT_W     = LENGTH_BITS + 2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COPY
    } t_state;

    logic [7:0] mem [DEPTH];

    t_state                r_state;
    logic [INDEX_BITS-1:0] r_clr_addr;
    logic [INDEX_BITS-1:0] r_wp;
    logic [INDEX_BITS-1:0] r_rd_addr;
    logic [CNT_W-1:0]      r_iss_cnt;
    logic [CNT_W-1:0]      r_out_cnt;
    logic                  r_pend;
    logic [7:0]            r_rd_q;
    logic                  r_out_valid;
    logic [7:0]            r_data_byte;
    logic                  r_data_valid;
    logic                  r_eos;
    logic                  r_last;

    logic                  slot_free;
    logic                  tok_acc;
    logic                  consume;
    logic                  issue;
    logic                  we;
    logic [INDEX_BITS-1:0] wa;
    logic [7:0]            wd;
    logic [CNT_W-1:0]      copy_count;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_tok_ready = (r_state == ST_IDLE) && slot_free;
    assign tok_acc     = i_tok_valid && o_tok_ready;
    assign consume     = r_pend && slot_free;
    assign issue       = (r_state == ST_COPY) && (r_iss_cnt != '0) && (!r_pend || consume);
    assign copy_count  = CNT_W'(i_tok_len) + CNT_W'(COPY_BIAS + 1);

    always_comb begin
        we = 1'b0;
        wa = r_wp;
        wd = r_rd_q;
        if (r_state == ST_CLEAR) begin
            we = 1'b1;
            wa = r_clr_addr;
            wd = 8'd0;
        end else if (tok_acc && (i_tok_kind == TOK_LIT)) begin
            we = 1'b1;
            wd = i_tok_lit;
        end else if (consume) begin
            we = 1'b1;
        end
    end

    // A read that hits the address written in the same cycle takes the new byte,
    // which covers a copy whose source trails the write pointer by one.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (issue) begin
            r_rd_q <= (we && (wa == r_rd_addr)) ? wd : mem[r_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_wp        <= INDEX_BITS'(1);
            r_iss_cnt   <= '0;
            r_out_cnt   <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (issue) begin
                r_pend <= 1'b1;
            end else if (consume) begin
                r_pend <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + INDEX_BITS'(1);
                    if (r_clr_addr == '1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (tok_acc) begin
                        case (i_tok_kind)
                            TOK_LIT: begin
                                r_wp         <= r_wp + INDEX_BITS'(1);
                                r_out_valid  <= 1'b1;
                                r_data_byte  <= i_tok_lit;
                                r_data_valid <= 1'b1;
                                r_eos        <= 1'b0;
                                r_last       <= 1'b1;
                            end
                            TOK_END: begin
                                r_wp         <= INDEX_BITS'(1);
                                r_out_valid  <= 1'b1;
                                r_data_byte  <= 8'd0;
                                r_data_valid <= 1'b0;
                                r_eos        <= 1'b1;
                                r_last       <= 1'b1;
                            end
                            TOK_MATCH: begin
                                r_rd_addr <= i_tok_pos;
                                r_iss_cnt <= copy_count;
                                r_out_cnt <= copy_count;
                                r_state   <= ST_COPY;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_COPY: begin
                    if (issue) begin
                        r_rd_addr <= r_rd_addr + INDEX_BITS'(1);
                        r_iss_cnt <= r_iss_cnt - CNT_W'(1);
                    end
                    if (consume) begin
                        r_wp         <= r_wp + INDEX_BITS'(1);
                        r_out_cnt    <= r_out_cnt - CNT_W'(1);
                        r_out_valid  <= 1'b1;
                        r_data_byte  <= r_rd_q;
                        r_data_valid <= 1'b1;
                        r_eos        <= 1'b0;
                        r_last       <= (r_out_cnt == CNT_W'(1));
                        if (r_out_cnt == CNT_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_clear_done  = (r_state != ST_CLEAR);
    assign o_out_valid   = r_out_valid;
    assign o_data_byte   = r_data_byte;
    assign o_data_valid  = r_data_valid;
    assign o_stream_end  = r_eos;
    assign o_last_of_run = r_last;

endmodule

/* rtl/core/lzss_stream_expander.sv */
// LZSS stream expander top level: bit-serial unpacker feeding the window copy engine.
// Each compressed byte is unpacked one bit per cycle while no token waits for the window.
// A literal goes to the output register when the window takes its token; a match with length
// field N copies N + 2 bytes via the single window read port and a read register, one word
// per cycle unless the output stalls, and no new token is taken until the copy is done.
// Synchronous reset, then a clearing pass of 2^INDEX_BITS entries during which no byte is taken.
module lzss_stream_expander
    import lzss_pkg::*;
#(
    parameter int INDEX_BITS  = 12,
    parameter int LENGTH_BITS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_data_byte,
    output logic       o_data_valid,
    output logic       o_stream_end,
    output logic       o_last_of_run
);

    logic                   clear_done;
    logic                   tok_valid;
    logic                   tok_ready;
    t_tok_kind              tok_kind;
    logic [LIT_BITS-1:0]    tok_lit;
    logic [INDEX_BITS-1:0]  tok_pos;
    logic [LENGTH_BITS-1:0] tok_len;

    lzss_unpack #(
        .INDEX_BITS  (INDEX_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_unpack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enable    (clear_done),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .o_tok_valid (tok_valid),
        .i_tok_ready (tok_ready),
        .o_tok_kind  (tok_kind),
        .o_tok_lit   (tok_lit),
        .o_tok_pos   (tok_pos),
        .o_tok_len   (tok_len)
    );

    lzss_window #(
        .INDEX_BITS  (INDEX_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .o_clear_done  (clear_done),
        .i_tok_valid   (tok_valid),
        .o_tok_ready   (tok_ready),
        .i_tok_kind    (tok_kind),
        .i_tok_lit     (tok_lit),
        .i_tok_pos     (tok_pos),
        .i_tok_len     (tok_len),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_data_byte   (o_data_byte),
        .o_data_valid  (o_data_valid),
        .o_stream_end  (o_stream_end),
        .o_last_of_run (o_last_of_run)
    );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the LZSS stream expander: token stimulus, predictor, scoreboard.
module tb;

    localparam int IDX_W          = 12;
    localparam int LEN_W          = 4;
    localparam int MIN_COPY       = (1 + IDX_W + LEN_W) / 9 + 1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_WORDS   = 210;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       stream_end;
        logic       last_of_run;
    } t_out_word;

    class expander_scoreboard;
        logic [7:0]       window [0:(1 << IDX_W) - 1];
        logic [IDX_W-1:0] wr_ptr;
        logic [31:0]      acc;
        int unsigned      held;
        t_out_word        expected_words[$];
        int unsigned      errors;

        function new();
            foreach (window[i]) window[i] = 8'h00;
            wr_ptr = IDX_W'(1);
            acc    = 0;
            held   = 0;
            errors = 0;
        endfunction

        // Value of n bits taken skip bits below the top of the held bits.
        function logic [31:0] peek(int unsigned skip, int unsigned n);
            return (acc >> (held - skip - n)) & ((32'd1 << n) - 32'd1);
        endfunction

        function void drop(int unsigned n);
            held -= n;
            acc &= (32'd1 << held) - 32'd1;
        endfunction

        function void store(logic [7:0] c);
            window[wr_ptr] = c;
            wr_ptr = wr_ptr + 1'b1;
        endfunction

        // Unpacks one accepted input word and queues every output word it completes.
        function void decode_byte(logic [7:0] b);
            t_out_word        run_q[$];
            t_out_word        w;
            logic [IDX_W-1:0] pos;
            logic [IDX_W-1:0] rd;
            int unsigned      len;
            bit               more;
            acc  = (acc << 8) | b;
            held += 8;
            more = 1'b1;
            while (more) begin
                if (held < 1) begin
                    more = 1'b0;
                end else if (peek(0, 1) == 1) begin
                    if (held < 9) begin
                        more = 1'b0;
                    end else begin
                        w.data_byte   = 8'(peek(1, 8));
                        w.data_valid  = 1'b1;
                        w.stream_end  = 1'b0;
                        w.last_of_run = 1'b0;
                        drop(9);
                        run_q.push_back(w);
                        store(w.data_byte);
                    end
                end else if (held < 1 + IDX_W) begin
                    more = 1'b0;
                end else begin
                    pos = IDX_W'(peek(1, IDX_W));
                    if (pos == 0) begin
                        w.data_byte   = 8'h00;
                        w.data_valid  = 1'b0;
                        w.stream_end  = 1'b1;
                        w.last_of_run = 1'b0;
                        run_q.push_back(w);
                        acc    = 0;
                        held   = 0;
                        wr_ptr = IDX_W'(1);
                        more   = 1'b0;
                    end else if (held < 1 + IDX_W + LEN_W) begin
                        more = 1'b0;
                    end else begin
                        len = peek(1 + IDX_W, LEN_W);
                        drop(1 + IDX_W + LEN_W);
                        for (int i = 0; i < len + MIN_COPY; i++) begin
                            rd = IDX_W'(pos + i);
                            w.data_byte   = window[rd];
                            w.data_valid  = 1'b1;
                            w.stream_end  = 1'b0;
                            w.last_of_run = 1'b0;
                            run_q.push_back(w);
                            store(w.data_byte);
                        end
                    end
                end
            end
            if (run_q.size() > 0) run_q[run_q.size() - 1].last_of_run = 1'b1;
            foreach (run_q[i]) expected_words.push_back(run_q[i]);
        endfunction

        function void check_word(logic [7:0] data_byte, logic data_valid,
                                 logic stream_end, logic last_of_run);
            t_out_word w;
            if (expected_words.size() == 0) begin
                $error("unexpected output word: data_byte=%h data_valid=%b end=%b last=%b",
                       data_byte, data_valid, stream_end, last_of_run);
                errors++;
                return;
            end
            w = expected_words.pop_front();
            if (data_byte !== w.data_byte) begin
                $error("data_byte: expected %h, actual %h", w.data_byte, data_byte);
                errors++;
            end
            if (data_valid !== w.data_valid) begin
                $error("data_valid: expected %b, actual %b", w.data_valid, data_valid);
                errors++;
            end
            if (stream_end !== w.stream_end) begin
                $error("stream_end: expected %b, actual %b", w.stream_end, stream_end);
                errors++;
            end
            if (last_of_run !== w.last_of_run) begin
                $error("last_of_run: expected %b, actual %b", w.last_of_run, last_of_run);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_data_byte;
    logic       o_data_valid;
    logic       o_stream_end;
    logic       o_last_of_run;

    expander_scoreboard sb;
    expander_scoreboard stream_model;
    bit                 token_bits[$];
    logic [7:0]         stim_bytes[$];
    int unsigned        send_idle_pct = 0;
    int unsigned        recv_idle_pct = 0;
    int unsigned        idle_cycles   = 0;

    lzss_stream_expander dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_data_byte   (o_data_byte),
        .o_data_valid  (o_data_valid),
        .o_stream_end  (o_stream_end),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Moves whole bytes of the token bit stream into the stimulus list.
    // The stream model tracks where the decoder stands in the stream.
    task automatic flush_bytes();
        logic [7:0] b;
        while (token_bits.size() >= 8) begin
            b = 8'h00;
            repeat (8) b = {b[6:0], token_bits.pop_front()};
            stim_bytes.push_back(b);
            stream_model.decode_byte(b);
        end
        stream_model.expected_words.delete();
    endtask

    task automatic push_bits(logic [31:0] value, int unsigned n);
        for (int i = n - 1; i >= 0; i--) token_bits.push_back(value[i]);
        flush_bytes();
    endtask

    task automatic pad_to_byte();
        while (token_bits.size() % 8 != 0) token_bits.push_back(1'($urandom_range(0, 1)));
        flush_bytes();
    endtask

    task automatic add_literal(logic [7:0] c);
        push_bits({23'd0, 1'b1, c}, 9);
    endtask

    task automatic add_match(logic [IDX_W-1:0] pos, logic [LEN_W-1:0] len);
        push_bits({15'd0, 1'b0, pos, len}, 1 + IDX_W + LEN_W);
    endtask

    // The rest of the byte holding an end marker is dropped, so fill it with junk.
    task automatic add_end_marker();
        push_bits(32'd0, 1 + IDX_W);
        pad_to_byte();
    endtask

    task automatic add_random_match();
        logic [IDX_W-1:0] pos;
        if ($urandom_range(0, 99) < 60) begin
            pos = IDX_W'(stream_model.wr_ptr - $urandom_range(1, 40));
            if (pos == 0) pos = '1;
        end else begin
            pos = IDX_W'($urandom_range(1, (1 << IDX_W) - 1));
        end
        add_match(pos, LEN_W'($urandom_range(0, (1 << LEN_W) - 1)));
    endtask

    task automatic build_stimulus();
        int unsigned target;
        // Literals at both extremes, overlapping run copy, wrapping copy, end markers.
        add_literal(8'h00);
        add_literal(8'hFF);
        add_literal(8'hA5);
        add_literal(8'h5A);
        add_match(12'd4, 4'hF);
        add_match(12'hFFF, 4'hF);
        add_match(12'd1, 4'h0);
        add_end_marker();
        add_literal(8'h80);
        add_end_marker();
        // The window survives the end marker, so the copy reads the previous stream.
        add_match(12'd2, 4'h3);
        add_literal(8'h7F);
        add_end_marker();

        target = stim_bytes.size() + RANDOM_WORDS;
        while (stim_bytes.size() < target) begin
            if ($urandom_range(0, 99) < 85) begin
                repeat ($urandom_range(1, 24)) begin
                    if ($urandom_range(0, 99) < 55) add_literal(8'($urandom_range(0, 255)));
                    else add_random_match();
                end
                if ($urandom_range(0, 99) < 35) add_end_marker();
            end else begin
                // Raw noise, then zero bytes until an end marker lines the decoder up again.
                pad_to_byte();
                repeat ($urandom_range(1, 8)) push_bits($urandom_range(0, 255), 8);
                while (stream_model.held != 0) push_bits(32'd0, 8);
            end
        end
        pad_to_byte();
    endtask

    task automatic send_word(logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_in_byte  <= 8'($urandom_range(0, 255));
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        forever begin
            @(posedge i_clk);
            if (i_in_valid && o_in_ready) break;
        end
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.decode_byte(i_in_byte);
            if (o_out_valid && i_out_ready)
                sb.check_word(o_data_byte, o_data_valid, o_stream_end, o_last_of_run);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned total;
        sb           = new();
        stream_model = new();
        build_stimulus();
        total = stim_bytes.size();

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < total; k++) begin
            if (k < total / 3) begin
                send_idle_pct = 30;
                recv_idle_pct = 81;
            end else if (k < 2 * total / 3) begin
                send_idle_pct = 81;
                recv_idle_pct = 30;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_word(stim_bytes[k]);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.expected_words.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/core/lzss_pkg.sv
rtl/core/lzss_unpack.sv
rtl/core/lzss_window.sv
rtl/core/lzss_stream_expander.sv
tb/tb.sv
